// ===== hdl/bsgb_pkg.sv =====
// ----------------------------------------------------------------------------
// Block sparsity graph builder package
// Shared widths, action codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package bsgb_pkg;

    localparam int NUM_W      = 9;   // matrix index width
    localparam int DIM_W      = 4;   // block_dim register width
    localparam int DIV_W      = 5;   // divisor width after clamping
    localparam int VTX_W      = 6;   // vertex / degree field width
    localparam int STEP_W     = 4;   // division step counter width
    localparam int DEF_MAX_BLOCKS    = 64;
    localparam int DEF_MAX_BLOCK_DIM = 8;
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHK,
        ST_RD1,
        ST_RMW1,
        ST_RMW2,
        ST_QRD,
        ST_CNT,
        ST_EMIT,
        ST_RESP
    } state_t;

endpackage

// ===== hdl/block_sparsity_graph_builder.sv =====
// ----------------------------------------------------------------------------
// Block sparsity graph builder
// Collapses matrix nonzeros into a symmetric block adjacency bitmap and reads
// back one block row as an ascending neighbour list with its degree.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item: action, matrix_col,
//   matrix_row, query_vertex. in_stall is high while an item is in progress;
//   one item is handled at a time.
//   Output channel (out_valid / out_stall) carries result items through a
//   single output register; a stalled result holds and the sequencer waits.
//   Config channel (cfg_valid / cfg_ready) writes block_dim; write only when
//   the block is idle.
// Steps per item:
//   clear: straight to its result. add: bit-serial divide of column then row,
//   one quotient bit per cycle, then the read-modify-write of both rows
//   through the single memory port (skipped for an ignored or diagonal add).
//   read: popcount scan, one bit per cycle, then the neighbour scan (skipped
//   for an empty row); the neighbour scan waits while a result is stalled.
// Reset: the adjacency store is empty (per-row valid bits are cleared, also
//   by a clear item), block_dim returns to 3, no result pending.
// ----------------------------------------------------------------------------
module block_sparsity_graph_builder
    import bsgb_pkg::*;
#(
    parameter int MAX_BLOCKS    = DEF_MAX_BLOCKS,
    parameter int MAX_BLOCK_DIM = DEF_MAX_BLOCK_DIM
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic [NUM_W-1:0] matrix_col,
    input  logic [NUM_W-1:0] matrix_row,
    input  logic [VTX_W-1:0] query_vertex,

    output logic             out_valid,
    input  logic             out_stall,
    output logic [VTX_W-1:0] neighbour,
    output logic             has_neighbour,
    output logic [VTX_W-1:0] degree,
    output logic             out_of_range,
    output logic             last,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [DIM_W-1:0] cfg_data
);

    localparam int BW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    state_t               state_reg, state_next;
    logic [DIM_W-1:0]     dim_reg;
    logic [DIV_W-1:0]     dim_eff;

    logic [NUM_W-1:0]     row_reg, row_next;
    logic [VTX_W-1:0]     qv_reg, qv_next;

    logic [NUM_W-1:0]     dvd_reg, dvd_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 phase_reg, phase_next;
    logic [NUM_W-1:0]     bc_reg, bc_next;
    logic [NUM_W-1:0]     br_reg, br_next;

    logic [BW-1:0]        j_reg, j_next;
    logic [CNT_W-1:0]     deg_reg, deg_next;
    logic [CNT_W-1:0]     k_reg, k_next;

    logic                 ov_reg, ov_next;
    logic [VTX_W-1:0]     nb_reg, nb_next;
    logic                 has_reg, has_next;
    logic [VTX_W-1:0]     dg_reg, dg_next;
    logic                 oor_reg, oor_next;
    logic                 last_reg, last_next;
    logic                 resp_oor_reg, resp_oor_next;

    logic [MAX_BLOCKS-1:0] mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] row_vld_reg, row_vld_next;
    logic [MAX_BLOCKS-1:0] rd_reg;
    logic                  rd_vld_reg;
    logic [MAX_BLOCKS-1:0] rowbits;
    logic [MAX_BLOCKS-1:0] set_mask;
    logic                  mem_we;
    logic [BW-1:0]         mem_waddr;
    logic [BW-1:0]         mem_raddr;
    logic [MAX_BLOCKS-1:0] mem_wdata;

    logic [DIV_W:0]        div_shift;
    logic                  div_ge;
    logic [DIV_W:0]        div_diff;
    logic [NUM_W-1:0]      quo_step;
    logic                  out_free;
    logic                  in_acc;

    // effective block size: 0 -> 1, clamp to MAX_BLOCK_DIM
    always_comb
    begin
        if (dim_reg == '0)
            dim_eff = DIV_W'(1);
        else if ({1'b0, dim_reg} > DIV_W'(MAX_BLOCK_DIM))
            dim_eff = DIV_W'(MAX_BLOCK_DIM);
        else
            dim_eff = {1'b0, dim_reg};
    end

    // shared restoring divider step
    assign div_shift = {rem_reg, dvd_reg[NUM_W-1]};
    assign div_ge    = div_shift >= {1'b0, dim_eff};
    assign div_diff  = div_shift - {1'b0, dim_eff};
    assign quo_step  = {quo_reg[NUM_W-2:0], div_ge};

    assign rowbits  = rd_vld_reg ? rd_reg : '0;
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        qv_next       = qv_reg;
        dvd_next      = dvd_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        phase_next    = phase_reg;
        bc_next       = bc_reg;
        br_next       = br_reg;
        j_next        = j_reg;
        deg_next      = deg_reg;
        k_next        = k_reg;
        resp_oor_next = resp_oor_reg;
        row_vld_next  = row_vld_reg;
        nb_next       = nb_reg;
        has_next      = has_reg;
        dg_next       = dg_reg;
        oor_next      = oor_reg;
        last_next     = last_reg;
        ov_next       = ov_reg && out_stall;
        mem_we        = 1'b0;
        mem_waddr     = bc_reg[BW-1:0];
        mem_raddr     = qv_reg[BW-1:0];
        set_mask      = '0;
        mem_wdata     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    row_next      = matrix_row;
                    qv_next       = query_vertex;
                    resp_oor_next = 1'b0;
                    unique case (action_t'(action))
                        ACT_CLEAR:
                        begin
                            row_vld_next = '0;
                            state_next   = ST_RESP;
                        end
                        ACT_ADD:
                        begin
                            dvd_next   = matrix_col;
                            quo_next   = '0;
                            rem_next   = '0;
                            step_next  = '0;
                            phase_next = 1'b0;
                            state_next = ST_DIV;
                        end
                        ACT_READ:
                        begin
                            if ({1'b0, query_vertex} >= (VTX_W+1)'(MAX_BLOCKS))
                            begin
                                resp_oor_next = 1'b1;
                                state_next    = ST_RESP;
                            end
                            else
                                state_next = ST_QRD;
                        end
                        default:
                            state_next = ST_RESP;
                    endcase
                end
            end

            ST_DIV:
            begin
                dvd_next  = {dvd_reg[NUM_W-2:0], 1'b0};
                quo_next  = quo_step;
                rem_next  = div_ge ? div_diff[DIV_W-1:0] : div_shift[DIV_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_W-1))
                begin
                    if (!phase_reg)
                    begin
                        bc_next    = quo_step;
                        dvd_next   = row_reg;
                        quo_next   = '0;
                        rem_next   = '0;
                        step_next  = '0;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        br_next    = quo_step;
                        state_next = ST_CHK;
                    end
                end
            end

            ST_CHK:
            begin
                if (bc_reg >= NUM_W'(MAX_BLOCKS) || br_reg >= NUM_W'(MAX_BLOCKS))
                begin
                    resp_oor_next = 1'b1;
                    state_next    = ST_RESP;
                end
                else if (bc_reg == br_reg)
                    state_next = ST_RESP;
                else
                    state_next = ST_RD1;
            end

            ST_RD1:
            begin
                mem_raddr  = bc_reg[BW-1:0];
                state_next = ST_RMW1;
            end

            ST_RMW1:
            begin
                set_mask[br_reg[BW-1:0]] = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = bc_reg[BW-1:0];
                mem_wdata  = rowbits | set_mask;
                mem_raddr  = br_reg[BW-1:0];
                row_vld_next[bc_reg[BW-1:0]] = 1'b1;
                state_next = ST_RMW2;
            end

            ST_RMW2:
            begin
                set_mask[bc_reg[BW-1:0]] = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = br_reg[BW-1:0];
                mem_wdata  = rowbits | set_mask;
                row_vld_next[br_reg[BW-1:0]] = 1'b1;
                state_next = ST_RESP;
            end

            ST_QRD:
            begin
                mem_raddr  = qv_reg[BW-1:0];
                j_next     = '0;
                deg_next   = '0;
                state_next = ST_CNT;
            end

            ST_CNT:
            begin
                deg_next = deg_reg + CNT_W'(rowbits[j_reg]);
                j_next   = j_reg + BW'(1);
                if (j_reg == BW'(MAX_BLOCKS-1))
                begin
                    j_next = '0;
                    k_next = '0;
                    if (deg_next == '0)
                        state_next = ST_RESP;
                    else
                        state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!rowbits[j_reg])
                    j_next = j_reg + BW'(1);
                else if (out_free)
                begin
                    ov_next   = 1'b1;
                    nb_next   = VTX_W'(j_reg);
                    has_next  = 1'b1;
                    dg_next   = VTX_W'(deg_reg);
                    oor_next  = 1'b0;
                    last_next = (k_reg + CNT_W'(1)) == deg_reg;
                    k_next    = k_reg + CNT_W'(1);
                    j_next    = j_reg + BW'(1);
                    if ((k_reg + CNT_W'(1)) == deg_reg)
                        state_next = ST_IDLE;
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    nb_next    = '0;
                    has_next   = 1'b0;
                    dg_next    = '0;
                    oor_next   = resp_oor_reg;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            dim_reg      <= DIM_RESET;
            row_vld_reg  <= '0;
            ov_reg       <= 1'b0;
            row_reg      <= '0;
            qv_reg       <= '0;
            dvd_reg      <= '0;
            quo_reg      <= '0;
            rem_reg      <= '0;
            step_reg     <= '0;
            phase_reg    <= 1'b0;
            bc_reg       <= '0;
            br_reg       <= '0;
            j_reg        <= '0;
            deg_reg      <= '0;
            k_reg        <= '0;
            resp_oor_reg <= 1'b0;
            nb_reg       <= '0;
            has_reg      <= 1'b0;
            dg_reg       <= '0;
            oor_reg      <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_valid && cfg_ready)
                dim_reg <= cfg_data;
            row_vld_reg  <= row_vld_next;
            ov_reg       <= ov_next;
            row_reg      <= row_next;
            qv_reg       <= qv_next;
            dvd_reg      <= dvd_next;
            quo_reg      <= quo_next;
            rem_reg      <= rem_next;
            step_reg     <= step_next;
            phase_reg    <= phase_next;
            bc_reg       <= bc_next;
            br_reg       <= br_next;
            j_reg        <= j_next;
            deg_reg      <= deg_next;
            k_reg        <= k_next;
            resp_oor_reg <= resp_oor_next;
            nb_reg       <= nb_next;
            has_reg      <= has_next;
            dg_reg       <= dg_next;
            oor_reg      <= oor_next;
            last_reg     <= last_next;
        end
    end

    // adjacency store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_reg     <= mem[mem_raddr];
        rd_vld_reg <= row_vld_reg[mem_raddr];
    end

    assign out_valid     = ov_reg;
    assign neighbour     = nb_reg;
    assign has_neighbour = has_reg;
    assign degree        = dg_reg;
    assign out_of_range  = oor_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    a_has_deg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_neighbour |-> degree != '0)
        else $error("neighbour result with zero degree");

    a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_neighbour |-> degree == '0 && neighbour == '0 && last)
        else $error("acknowledgment carries data");

    a_no_self: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> mem_wdata[mem_waddr] == 1'b0)
        else $error("self loop written to store");

    a_emit_deg: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> deg_reg != '0 && k_reg < deg_reg)
        else $error("neighbour scan past degree");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg != ST_IDLE)
        else $error("accepted item not started");
`endif

endmodule

// ===== test/tb_block_sparsity_graph_builder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block sparsity graph builder testbench
// Streams clear, add, read and unused-action items into the block under
// random input gaps and output stalls. Runs several block_dim settings,
// including the clamped ones, and one phase that fills a row to full degree.
// A scoreboard keeps its own copy of the block adjacency bitmap, predicts the
// result items of every accepted item and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_block_sparsity_graph_builder;
    import bsgb_pkg::*;

    typedef struct packed {
        logic [VTX_W-1:0] nb;
        logic             has;
        logic [VTX_W-1:0] deg;
        logic             oor;
        logic             last;
    } graph_result_t;

    class graph_scoreboard;
        logic [DEF_MAX_BLOCKS-1:0] adjacency_rows [DEF_MAX_BLOCKS];
        logic [DIM_W-1:0]          block_size;
        graph_result_t             pending_results [$];
        int                        errors;

        function new();
            foreach (adjacency_rows[i])
                adjacency_rows[i] = '0;
            block_size = DIM_RESET;
            errors     = 0;
        endfunction

        function int unsigned eff_dim();
            if (block_size == 0)
                return 1;
            if (block_size > DEF_MAX_BLOCK_DIM)
                return DEF_MAX_BLOCK_DIM;
            return block_size;
        endfunction

        function void note_item(action_t act, logic [NUM_W-1:0] col,
                                logic [NUM_W-1:0] row, logic [VTX_W-1:0] q);
            int unsigned   d;
            int unsigned   bc;
            int unsigned   br;
            int unsigned   deg;
            int unsigned   k;
            graph_result_t r;
            r      = '0;
            r.last = 1'b1;
            case (act)
                ACT_CLEAR:
                begin
                    foreach (adjacency_rows[i])
                        adjacency_rows[i] = '0;
                    pending_results.push_back(r);
                end
                ACT_ADD:
                begin
                    d  = eff_dim();
                    bc = col / d;
                    br = row / d;
                    if (bc >= DEF_MAX_BLOCKS || br >= DEF_MAX_BLOCKS)
                        r.oor = 1'b1;
                    else if (bc != br)
                    begin
                        adjacency_rows[bc][br] = 1'b1;
                        adjacency_rows[br][bc] = 1'b1;
                    end
                    pending_results.push_back(r);
                end
                ACT_READ:
                begin
                    deg = $countones(adjacency_rows[q]);
                    if (deg == 0)
                        pending_results.push_back(r);
                    else
                    begin
                        k = 0;
                        for (int j = 0; j < DEF_MAX_BLOCKS; j++)
                        begin
                            if (adjacency_rows[q][j])
                            begin
                                r.nb   = j[VTX_W-1:0];
                                r.has  = 1'b1;
                                r.deg  = deg[VTX_W-1:0];
                                r.last = (k + 1 == deg);
                                pending_results.push_back(r);
                                k++;
                            end
                        end
                    end
                end
                default:
                    pending_results.push_back(r);
            endcase
        endfunction

        function void check_result(graph_result_t got);
            graph_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: neighbour %0d has %0d degree %0d oor %0d last %0d",
                       got.nb, got.has, got.deg, got.oor, got.last);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.nb !== want.nb)
            begin
                $error("neighbour: expected %0d actual %0d", want.nb, got.nb);
                errors++;
            end
            if (got.has !== want.has)
            begin
                $error("has_neighbour: expected %0d actual %0d", want.has, got.has);
                errors++;
            end
            if (got.deg !== want.deg)
            begin
                $error("degree: expected %0d actual %0d", want.deg, got.deg);
                errors++;
            end
            if (got.oor !== want.oor)
            begin
                $error("out_of_range: expected %0d actual %0d", want.oor, got.oor);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [1:0]       action;
    logic [NUM_W-1:0] matrix_col;
    logic [NUM_W-1:0] matrix_row;
    logic [VTX_W-1:0] query_vertex;
    logic             out_valid;
    logic             out_stall;
    logic [VTX_W-1:0] neighbour;
    logic             has_neighbour;
    logic [VTX_W-1:0] degree;
    logic             out_of_range;
    logic             last;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [DIM_W-1:0] cfg_data;

    bit               calm;
    graph_scoreboard  sb = new();

    block_sparsity_graph_builder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .matrix_col    (matrix_col),
        .matrix_row    (matrix_row),
        .query_vertex  (query_vertex),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .neighbour     (neighbour),
        .has_neighbour (has_neighbour),
        .degree        (degree),
        .out_of_range  (out_of_range),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // mostly short, a few long
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result({neighbour, has_neighbour, degree, out_of_range, last});
            if (in_valid && !in_stall)
                sb.note_item(action_t'(action), matrix_col, matrix_row, query_vertex);
            if (cfg_valid && cfg_ready)
                sb.block_size = cfg_data;
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (calm || out_stall)
            begin
                out_stall <= 1'b0;
                hold = idle_len() + $urandom_range(0, 6);
            end
            else
            begin
                out_stall <= 1'b1;
                hold = idle_len();
            end
        end
    end

    task automatic push_item(action_t act, int row, int col, int q);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        matrix_row   <= row[NUM_W-1:0];
        matrix_col   <= col[NUM_W-1:0];
        query_vertex <= q[VTX_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_block_dim(logic [DIM_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count);
        int unsigned r;
        int unsigned d;
        int unsigned lim;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            d = sb.eff_dim();
            if (r < 3)
                push_item(ACT_CLEAR, $urandom_range(0, 511), $urandom_range(0, 511),
                          $urandom_range(0, 63));
            else if (r < 6)
                push_item(ACT_NONE, $urandom_range(0, 511), $urandom_range(0, 511),
                          $urandom_range(0, 63));
            else if (r < 62)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    lim = 511;
                else if (r < 4)
                    lim = 8 * d - 1;
                else
                    lim = (64 * d > 512) ? 511 : 64 * d - 1;
                push_item(ACT_ADD, $urandom_range(0, lim), $urandom_range(0, lim),
                          $urandom_range(0, 63));
            end
            else
                push_item(ACT_READ, $urandom_range(0, 511), $urandom_range(0, 511),
                          ($urandom_range(0, 9) < 4) ? $urandom_range(0, 7)
                                                     : $urandom_range(0, 63));
        end
    endtask

    // every other block joined to block 0, then row 0 is read back in full, and rows 63 and 32
    task automatic build_star();
        int unsigned d;
        d = sb.eff_dim();
        push_item(ACT_CLEAR, 0, 0, 0);
        for (int k = 1; k < DEF_MAX_BLOCKS; k++)
            push_item(ACT_ADD, $urandom_range(0, d - 1), k * d + $urandom_range(0, d - 1), 0);
        push_item(ACT_READ, 0, 0, 0);
        push_item(ACT_READ, 0, 0, 63);
        push_item(ACT_READ, 511, 511, 32);
    endtask

    initial
    begin
        logic [DIM_W-1:0] dims [8];
        dims = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd7, 4'd4};

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_CLEAR;
        matrix_col   = '0;
        matrix_row   = '0;
        query_vertex = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        calm         = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // block_dim at its reset value of 3: blocks 0..63 cover rows 0..191
        push_item(ACT_CLEAR, 0, 0, 0);
        push_item(ACT_ADD, 0, 0, 0);
        push_item(ACT_ADD, 0, 3, 0);
        push_item(ACT_ADD, 5, 189, 0);
        push_item(ACT_ADD, 511, 511, 0);
        push_item(ACT_ADD, 200, 0, 0);
        push_item(ACT_ADD, 0, 192, 0);
        push_item(ACT_ADD, 191, 0, 0);
        push_item(ACT_READ, 0, 0, 0);
        push_item(ACT_READ, 0, 0, 1);
        push_item(ACT_READ, 0, 0, 63);
        push_item(ACT_READ, 0, 0, 62);
        push_item(ACT_NONE, 511, 511, 63);
        push_item(ACT_ADD, 2, 1, 0);
        push_item(ACT_CLEAR, 511, 511, 63);
        push_item(ACT_READ, 0, 0, 1);

        foreach (dims[p])
        begin
            write_block_dim(dims[p]);
            calm = (p % 3 == 2);
            if (dims[p] == 4'd8)
                build_star();
            run_random(55);
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
